[rtl/tos_pkg.sv]
// ----------------------------------------------------------------------------
// tos_pkg : shared definitions for the typed operand stack
// Field widths, operation and type codes, shift controls for the cell chains.
// ----------------------------------------------------------------------------
package tos_pkg;

    localparam int OPERAND_DEPTH_DEF = 128;

    localparam int WORD_W  = 32;
    localparam int VALUE_W = 64;
    localparam int TYPE_W  = 3;
    localparam int RTYPE_W = 4;
    localparam int KIND_W  = 2;
    localparam int USED_W  = 9;
    localparam int TAG_W   = TYPE_W + RTYPE_W;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

    // type codes
    localparam logic [TYPE_W-1:0] TY_INT    = 3'd0;
    localparam logic [TYPE_W-1:0] TY_LONG   = 3'd1;
    localparam logic [TYPE_W-1:0] TY_FLOAT  = 3'd2;
    localparam logic [TYPE_W-1:0] TY_DOUBLE = 3'd3;
    localparam logic [TYPE_W-1:0] TY_BOOL   = 3'd4;
    localparam logic [TYPE_W-1:0] TY_REF    = 3'd5;

    // per-cycle move for a whole chain: push shifts away from the top,
    // pop shifts towards it, neither holds
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_SECOND
    } t_state;

endpackage

[rtl/typed_operand_stack_core.sv]
// ----------------------------------------------------------------------------
// typed_operand_stack_core : typed operand stack of 32-bit slots
// Slot stack and tag stack held in shifting cell chains, one result per beat.
// ----------------------------------------------------------------------------
// The stack lives in two rows of cells with the top of stack always in cell 0:
// a slot row (2*OPERAND_DEPTH words of 32 bits) and an entry row of the same
// length holding the 3-bit type and 4-bit real-type tags. A push shifts a row
// down by one cell, a pop shifts it up by one, so every access reads or
// writes only the first two cells. Longs, doubles and (while wide_references
// is set) references take two slots, low word pushed first and high word on
// top. A push or pop of such a value shifts the slot row again in ST_SECOND,
// as the row moves one cell per cycle. The result beat is registered at the
// moment of acceptance and is offered from the next cycle. While it waits
// untaken no new beat is accepted; a result leaving at a clock edge lets the
// next beat in at that same edge. Overflowing pushes are refused with overflow
// set; pops and peeks of an empty stack return zeros with was_empty set. Push
// type codes 6 and 7 and operation code 3 change nothing. wide_references is
// written by i_cfg_we and should only change while the block is idle.
// ----------------------------------------------------------------------------
module typed_operand_stack_core #(
    parameter int OPERAND_DEPTH = tos_pkg::OPERAND_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tos_pkg::KIND_W-1:0]    i_kind,
    input  logic [tos_pkg::TYPE_W-1:0]    i_push_type,
    input  logic                          i_give_real_type,
    input  logic [tos_pkg::RTYPE_W-1:0]   i_real_type,
    input  logic [tos_pkg::VALUE_W-1:0]   i_push_value,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tos_pkg::VALUE_W-1:0]   o_tos_value,
    output logic [tos_pkg::TYPE_W-1:0]    o_tos_type,
    output logic [tos_pkg::RTYPE_W-1:0]   o_top_real_type,
    output logic                          o_was_empty,
    output logic                          o_overflow,
    output logic [tos_pkg::USED_W-1:0]    o_slots_used
);

    localparam int CAP   = 2 * OPERAND_DEPTH;
    localparam int PTR_W = $clog2(CAP + 1);
    localparam int EXT_W = (PTR_W > tos_pkg::USED_W) ? PTR_W : tos_pkg::USED_W;

    localparam logic [PTR_W:0]   CAP_X = (PTR_W + 1)'(CAP);
    localparam logic [PTR_W-1:0] CAP_P = PTR_W'(CAP);
    localparam logic [PTR_W-1:0] ONE_P = PTR_W'(1);
    localparam logic [PTR_W-1:0] TWO_P = PTR_W'(2);

    function automatic logic takes_two(input logic [tos_pkg::TYPE_W-1:0] t,
                                       input logic wide);
        takes_two = (t == tos_pkg::TY_LONG) || (t == tos_pkg::TY_DOUBLE) ||
                    ((t == tos_pkg::TY_REF) && wide);
    endfunction

    // ---------------------------------------------------------------- state
    tos_pkg::t_state                r_state;
    tos_pkg::t_state                n_state;
    logic                           r_wide_refs;
    logic [PTR_W-1:0]               r_slot_ptr;
    logic [PTR_W-1:0]               n_slot_ptr;
    logic [PTR_W-1:0]               r_entry_ptr;
    logic [PTR_W-1:0]               n_entry_ptr;

    // work for the second shift of a two-slot beat
    logic                           r_second_pop;
    logic [tos_pkg::WORD_W-1:0]     r_hi;

    // result register
    logic                           r_out_valid;
    logic [tos_pkg::VALUE_W-1:0]    r_tos_value;
    logic [tos_pkg::TYPE_W-1:0]     r_tos_type;
    logic [tos_pkg::RTYPE_W-1:0]    r_top_rtype;
    logic                           r_was_empty;
    logic                           r_overflow;
    logic [tos_pkg::USED_W-1:0]     r_slots_used;

    // chain interface
    tos_pkg::t_shift_ctl            w_slot_ctl;
    tos_pkg::t_shift_ctl            w_entry_ctl;
    logic [tos_pkg::WORD_W-1:0]     w_slot_din;
    logic [tos_pkg::WORD_W-1:0]     w_slot_top;
    logic [tos_pkg::WORD_W-1:0]     w_slot_next;
    logic [tos_pkg::TAG_W-1:0]      w_entry_din;
    logic [tos_pkg::TAG_W-1:0]      w_entry_top;

    // decode of the offered beat
    logic                           w_in_acc;
    logic                           w_out_acc;
    logic                           w_idle_ready;
    logic                           w_do_push;
    logic                           w_do_pop;
    logic                           w_two_shift;
    logic                           w_ovf;
    logic                           w_empty;
    logic                           w_push_two;
    logic                           w_pop_two;
    logic [tos_pkg::WORD_W-1:0]     w_lo;
    logic [tos_pkg::RTYPE_W-1:0]    w_push_rtype;
    logic [tos_pkg::TYPE_W-1:0]     w_rd_type;
    logic [tos_pkg::RTYPE_W-1:0]    w_rd_rtype;
    logic [tos_pkg::VALUE_W-1:0]    w_rd_value;
    logic [PTR_W:0]                 w_slot_sum;
    logic [EXT_W-1:0]               w_used_ext;

    assign w_in_acc     = i_in_valid & o_in_ready;
    assign w_out_acc    = r_out_valid & i_out_ready;
    // room for a result: register empty, or its beat leaves this edge
    assign w_idle_ready = ~r_out_valid | i_out_ready;

    assign w_rd_type  = w_entry_top[tos_pkg::TAG_W-1 -: tos_pkg::TYPE_W];
    assign w_rd_rtype = w_entry_top[tos_pkg::RTYPE_W-1:0];

    // ------------------------------------------------------- beat decode
    always_comb begin
        w_do_push    = 1'b0;
        w_do_pop     = 1'b0;
        w_two_shift  = 1'b0;
        w_ovf        = 1'b0;
        w_empty      = 1'b0;
        w_push_two   = takes_two(i_push_type, r_wide_refs);
        w_pop_two    = 1'b0;
        w_rd_value   = '0;
        w_slot_sum   = {1'b0, r_slot_ptr} + (w_push_two ? (PTR_W + 1)'(2)
                                                        : (PTR_W + 1)'(1));
        n_slot_ptr   = r_slot_ptr;
        n_entry_ptr  = r_entry_ptr;

        // bool keeps only whether its low byte is set
        if (i_push_type == tos_pkg::TY_BOOL) begin
            w_lo = tos_pkg::WORD_W'(|i_push_value[7:0]);
        end else begin
            w_lo = i_push_value[tos_pkg::WORD_W-1:0];
        end
        w_push_rtype = i_give_real_type ? i_real_type
                                        : tos_pkg::RTYPE_W'(i_push_type);

        case (i_kind)
            tos_pkg::KIND_PUSH: begin
                if (i_push_type inside {[tos_pkg::TY_INT : tos_pkg::TY_REF]}) begin
                    if ((w_slot_sum > CAP_X) || (r_entry_ptr >= CAP_P)) begin
                        w_ovf = 1'b1;
                    end else begin
                        w_do_push   = 1'b1;
                        w_two_shift = w_push_two;
                        n_slot_ptr  = w_slot_sum[PTR_W-1:0];
                        n_entry_ptr = r_entry_ptr + ONE_P;
                    end
                end
            end
            tos_pkg::KIND_POP, tos_pkg::KIND_PEEK: begin
                if ((r_entry_ptr == '0) || (r_slot_ptr == '0)) begin
                    w_empty = 1'b1;
                end else begin
                    w_pop_two = takes_two(w_rd_type, r_wide_refs);
                    if (w_pop_two) begin
                        // missing low slot reads as zero
                        w_rd_value = {w_slot_top,
                                      (r_slot_ptr >= TWO_P) ? w_slot_next
                                                            : tos_pkg::WORD_W'(0)};
                    end else begin
                        w_rd_value = tos_pkg::VALUE_W'(w_slot_top);
                    end
                    if (i_kind == tos_pkg::KIND_POP) begin
                        w_do_pop    = 1'b1;
                        w_two_shift = w_pop_two && (r_slot_ptr >= TWO_P);
                        n_slot_ptr  = r_slot_ptr - (w_two_shift ? TWO_P : ONE_P);
                        n_entry_ptr = r_entry_ptr - ONE_P;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign w_used_ext = EXT_W'(n_slot_ptr);

    // --------------------------------------------------- FSM next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tos_pkg::ST_IDLE: begin
                if (w_in_acc && w_two_shift) begin
                    n_state = tos_pkg::ST_SECOND;
                end
            end
            tos_pkg::ST_SECOND: begin
                n_state = tos_pkg::ST_IDLE;
            end
            default: begin
                n_state = tos_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------- FSM outputs
    always_comb begin
        o_in_ready        = 1'b0;
        w_slot_ctl        = '0;
        w_entry_ctl       = '0;
        w_slot_din        = w_lo;
        w_entry_din       = {i_push_type, w_push_rtype};
        case (r_state)
            tos_pkg::ST_IDLE: begin
                o_in_ready       = w_idle_ready;
                // low word goes first; the high word follows next cycle
                w_slot_ctl.push  = i_in_valid & w_idle_ready & w_do_push;
                w_slot_ctl.pop   = i_in_valid & w_idle_ready & w_do_pop;
                w_entry_ctl.push = i_in_valid & w_idle_ready & w_do_push;
                w_entry_ctl.pop  = i_in_valid & w_idle_ready & w_do_pop;
            end
            tos_pkg::ST_SECOND: begin
                w_slot_ctl.push = ~r_second_pop;
                w_slot_ctl.pop  = r_second_pop;
                w_slot_din      = r_hi;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------- control regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tos_pkg::ST_IDLE;
            r_wide_refs <= 1'b0;
            r_slot_ptr  <= '0;
            r_entry_ptr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_wide_refs <= i_cfg_wdata;
            end
            if (w_in_acc) begin
                r_slot_ptr  <= n_slot_ptr;
                r_entry_ptr <= n_entry_ptr;
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------- payload regs
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_second_pop <= w_do_pop;
            r_hi         <= i_push_value[tos_pkg::VALUE_W-1 -: tos_pkg::WORD_W];
            r_tos_value  <= w_rd_value;
            // tags only for a pop or peek that found an entry
            r_tos_type   <= (w_do_pop || (i_kind == tos_pkg::KIND_PEEK && !w_empty)) ?
                            w_rd_type : '0;
            r_top_rtype  <= (w_empty || i_kind == tos_pkg::KIND_PUSH) ? '0 :
                            ((w_do_pop || i_kind == tos_pkg::KIND_PEEK) ? w_rd_rtype
                                                                        : '0);
            r_was_empty  <= w_empty;
            r_overflow   <= w_ovf;
            r_slots_used <= w_used_ext[tos_pkg::USED_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tos_value     = r_tos_value;
    assign o_tos_type      = r_tos_type;
    assign o_top_real_type = r_top_rtype;
    assign o_was_empty     = r_was_empty;
    assign o_overflow      = r_overflow;
    assign o_slots_used    = r_slots_used;

    // ---------------------------------------------------------- chains
    tos_chain #(
        .N (CAP),
        .W (tos_pkg::WORD_W)
    ) u_slots (
        .i_clk       (i_clk),
        .i_ctl       (w_slot_ctl),
        .i_push_data (w_slot_din),
        .o_top       (w_slot_top),
        .o_next      (w_slot_next)
    );

    tos_chain #(
        .N (CAP),
        .W (tos_pkg::TAG_W)
    ) u_entries (
        .i_clk       (i_clk),
        .i_ctl       (w_entry_ctl),
        .i_push_data (w_entry_din),
        .o_top       (w_entry_top),
        .o_next      ()
    );

    // ------------------------------------------------------ assertions
    a_second_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tos_pkg::ST_SECOND) |-> !o_in_ready)
        else $error("beat accepted during second shift");

    a_second_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tos_pkg::ST_SECOND) |=> (r_state == tos_pkg::ST_IDLE))
        else $error("second shift did not finish in one cycle");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot_ptr <= CAP_P) && (r_entry_ptr <= CAP_P))
        else $error("stack pointer beyond capacity");

    a_ovf_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_ovf) |=>
            (r_slot_ptr == $past(r_slot_ptr)) && (r_entry_ptr == $past(r_entry_ptr)))
        else $error("refused push moved a pointer");

endmodule

[rtl/tos_cell.sv]
// ----------------------------------------------------------------------------
// tos_cell : one storage cell of a shifting stack chain
// Holds one word; loads from the neighbour above on push, below on pop.
// ----------------------------------------------------------------------------
module tos_cell #(
    parameter int W = tos_pkg::WORD_W
) (
    input  logic                  i_clk,
    input  tos_pkg::t_shift_ctl   i_ctl,
    input  logic [W-1:0]          i_from_above,
    input  logic [W-1:0]          i_from_below,
    output logic [W-1:0]          o_q
);

    logic [W-1:0] r_q;
    logic [W-1:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_ctl.push) begin
            n_q = i_from_above;
        end else if (i_ctl.pop) begin
            n_q = i_from_below;
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

[rtl/tos_chain.sv]
// ----------------------------------------------------------------------------
// tos_chain : row of stack cells, top of stack in cell 0
// All cells move together under one shift control; the bottom fills with 0.
// ----------------------------------------------------------------------------
module tos_chain #(
    parameter int N = 2 * tos_pkg::OPERAND_DEPTH_DEF,
    parameter int W = tos_pkg::WORD_W
) (
    input  logic                  i_clk,
    input  tos_pkg::t_shift_ctl   i_ctl,
    input  logic [W-1:0]          i_push_data,
    output logic [W-1:0]          o_top,
    output logic [W-1:0]          o_next
);

    logic [W-1:0] w_q [N];

    for (genvar g = 0; g < N; g++) begin : g_cell
        logic [W-1:0] w_above;
        logic [W-1:0] w_below;

        if (g == 0) begin : g_first
            assign w_above = i_push_data;
        end else begin : g_mid_a
            assign w_above = w_q[g-1];
        end

        if (g == N - 1) begin : g_last
            assign w_below = '0;
        end else begin : g_mid_b
            assign w_below = w_q[g+1];
        end

        tos_cell #(
            .W (W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_q          (w_q[g])
        );
    end

    assign o_top  = w_q[0];
    assign o_next = w_q[1];

endmodule
